/* sv/nfib_pkg.sv */
`default_nettype none

package nfib_pkg;

   // buffer geometry
   localparam int CAPACITY = 128;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int KIND_W   = 2;
   localparam int FRAC_W   = 17;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 7;

   // item operation codes
   typedef enum logic [KIND_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_POP   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED   = 3'd0,
      STAT_FULL    = 3'd1,
      STAT_POPPED  = 3'd2,
      STAT_DONE    = 3'd3,
      STAT_CLEARED = 3'd4
   } status_type;

   // running best candidate handed from cell to cell
   typedef struct packed {
      logic                found;
      logic [FRAC_W-1:0]   frac;
      logic [IDX_W-1:0]    idx;
      logic                kind;
      logic [HANDLE_W-1:0] handle;
   } cand_type;

   // broadcast command from the controller to every cell
   typedef struct packed {
      logic                clear;
      logic                wr_en;
      logic [IDX_W-1:0]    wr_idx;
      logic [FRAC_W-1:0]   frac;
      logic                kind;
      logic [HANDLE_W-1:0] handle;
      logic                consume_en;
      logic [IDX_W-1:0]    consume_idx;
   } cell_cmd_type;

   // one result item
   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [FRAC_W-1:0]   frac;
      logic                kind;
      logic [HANDLE_W-1:0] handle;
   } result_type;

endpackage

`default_nettype wire

/* sv/nfib_req_if.sv */
`default_nettype none

interface nfib_req_if
   import nfib_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [FRAC_W-1:0]   fraction;
   logic                item_kind;
   logic [HANDLE_W-1:0] handle;

   modport source (output valid, kind, fraction, item_kind, handle, input ready);
   modport sink   (input valid, kind, fraction, item_kind, handle, output ready);
endinterface

`default_nettype wire

/* sv/nfib_rsp_if.sv */
`default_nettype none

interface nfib_rsp_if
   import nfib_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [FRAC_W-1:0]   out_fraction;
   logic                out_item_kind;
   logic [HANDLE_W-1:0] out_handle;

   modport source (output valid, status, slot, out_fraction, out_item_kind, out_handle,
                   input ready);
   modport sink   (input valid, status, slot, out_fraction, out_item_kind, out_handle,
                   output ready);
endinterface

`default_nettype wire

/* sv/nfib_cell.sv */
`default_nettype none

module nfib_cell
   import nfib_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_idx,
   input  wire logic [CNT_W-1:0] fill_count,
   input  wire cell_cmd_type     cmd,
   input  wire logic             tok_in,
   input  wire cand_type         cand_in,
   output logic                  tok_out,
   output cand_type              cand_out
);

   logic [FRAC_W-1:0]   frac_ff,   frac_in;
   logic                kind_ff,   kind_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                consumed_ff, consumed_in;
   logic                tok_ff;
   cand_type            cand_ff, cand_in_next;
   logic                live;
   logic                take;

   // entry storage and consumed flag
   always_comb begin
      frac_in     = frac_ff;
      kind_in     = kind_ff;
      handle_in   = handle_ff;
      consumed_in = consumed_ff;
      if (cmd.wr_en && (cmd.wr_idx == cell_idx)) begin
         frac_in   = cmd.frac;
         kind_in   = cmd.kind;
         handle_in = cmd.handle;
      end
      priority if (cmd.clear) begin
         consumed_in = 1'b0;
      end else if (cmd.wr_en && (cmd.wr_idx == cell_idx)) begin
         consumed_in = 1'b0;
      end else if (cmd.consume_en && (cmd.consume_idx == cell_idx)) begin
         consumed_in = 1'b1;
      end else begin
         consumed_in = consumed_ff;
      end
   end

   // compare own entry against the incoming candidate, earlier entry wins a tie
   always_comb begin
      live = CNT_W'(cell_idx) < fill_count;
      take = live && !consumed_ff && (!cand_in.found || (frac_ff < cand_in.frac));
      cand_in_next = cand_in;
      if (take) begin
         cand_in_next.found  = 1'b1;
         cand_in_next.frac   = frac_ff;
         cand_in_next.idx    = cell_idx;
         cand_in_next.kind   = kind_ff;
         cand_in_next.handle = handle_ff;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff   <= frac_in;
      kind_ff   <= kind_in;
      handle_ff <= handle_in;
      cand_ff   <= cand_in_next;
      if (reset) begin
         consumed_ff <= 1'b0;
         tok_ff      <= 1'b0;
      end else begin
         consumed_ff <= consumed_in;
         tok_ff      <= tok_in;
      end
   end

   assign tok_out  = tok_ff;
   assign cand_out = cand_ff;

endmodule

`default_nettype wire

/* sv/nearest_first_intercept_buffer.sv */
// Nearest-first intercept buffer.
// req_chan carries items: kind (clear, add, pop, none), plus fraction,
// item_kind and handle for an add. rsp_chan returns exactly one result item
// per request item: status, slot and, for a pop, the popped entry's fraction,
// kind and handle. csr_wr_en / csr_wr_data set the Q1.16 pop cutoff; zero
// disables the cutoff. Entries live in a row of CAPACITY cells. A pop sends a
// candidate token down the row, one cell per cycle, each cell keeping the
// smaller fraction; when the token leaves the last cell, the best entry goes
// into the pending register and then into the output register. One item is
// worked on at a time; a new item is accepted as soon as the previous one has
// moved into the output register. The output register holds a result while
// rsp_chan.ready is low; the next item is still accepted and worked on, and
// its result waits until the output register frees up. Reset (synchronous)
// empties the buffer, clears the cutoff and drops any result in flight.
// Configuration must be written only while idle; the block does not check it.
`default_nettype none

module nearest_first_intercept_buffer
   import nfib_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   nfib_req_if.sink               req_chan,
   nfib_rsp_if.source             rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire logic [FRAC_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      FSM_IDLE = 3'b001,
      FSM_SCAN = 3'b010,
      FSM_DONE = 3'b100
   } fsm_type;

   fsm_type             state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [FRAC_W-1:0]   max_frac_ff;
   result_type          pend_ff, pend_in;
   result_type          rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                load_out;
   op_type              op;
   cell_cmd_type        cmd;
   logic                tok_chain  [CAPACITY+1];
   cand_type            cand_chain [CAPACITY+1];
   cand_type            best;
   logic                beyond;

   assign accept   = req_chan.valid && req_chan.ready;
   assign op       = op_type'(req_chan.kind);
   assign load_out = (state_ff == FSM_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign best     = cand_chain[CAPACITY];
   assign beyond   = (max_frac_ff != '0) && (best.frac > max_frac_ff);

   assign req_chan.ready = (state_ff == FSM_IDLE);

   // cell row
   assign tok_chain[0]  = accept && (op == OP_POP);
   assign cand_chain[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      nfib_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(i)),
         .fill_count (fill_ff),
         .cmd        (cmd),
         .tok_in     (tok_chain[i]),
         .cand_in    (cand_chain[i]),
         .tok_out    (tok_chain[i+1]),
         .cand_out   (cand_chain[i+1])
      );
   end

   // controller: broadcast command, pending result and next state
   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      pend_in         = pend_ff;
      cmd             = '0;
      cmd.wr_idx      = IDX_W'(fill_ff);
      cmd.frac        = req_chan.fraction;
      cmd.kind        = req_chan.item_kind;
      cmd.handle      = req_chan.handle;
      cmd.consume_idx = best.idx;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               pend_in = '0;
               state_in = FSM_DONE;
               unique case (op)
                  OP_CLEAR: begin
                     cmd.clear      = 1'b1;
                     fill_in        = '0;
                     pend_in.status = STAT_CLEARED;
                  end
                  OP_ADD: begin
                     if (fill_ff >= CNT_W'(CAPACITY)) begin
                        pend_in.status = STAT_FULL;
                     end else begin
                        cmd.wr_en      = 1'b1;
                        fill_in        = fill_ff + 1'b1;
                        pend_in.status = STAT_ADDED;
                        pend_in.slot   = SLOT_W'(fill_ff);
                     end
                  end
                  OP_POP: begin
                     state_in = FSM_SCAN;
                  end
                  OP_NONE: begin
                     pend_in.status = STAT_DONE;
                  end
                  default: begin
                     pend_in.status = STAT_DONE;
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            if (tok_chain[CAPACITY]) begin
               state_in = FSM_DONE;
               pend_in  = '0;
               if (!best.found || beyond) begin
                  pend_in.status = STAT_DONE;
               end else begin
                  cmd.consume_en = 1'b1;
                  pend_in.status = STAT_POPPED;
                  pend_in.slot   = SLOT_W'(best.idx);
                  pend_in.frac   = best.frac;
                  pend_in.kind   = best.kind;
                  pend_in.handle = best.handle;
               end
            end
         end
         FSM_DONE: begin
            if (load_out) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (load_out) begin
         rsp_ff <= pend_ff;
      end
      if (reset) begin
         state_ff     <= FSM_IDLE;
         fill_ff      <= '0;
         max_frac_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_frac_ff <= csr_wr_data;
         end
      end
   end

   // result channel
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_ff.status;
   assign rsp_chan.slot          = rsp_ff.slot;
   assign rsp_chan.out_fraction  = rsp_ff.frac;
   assign rsp_chan.out_item_kind = rsp_ff.kind;
   assign rsp_chan.out_handle    = rsp_ff.handle;

endmodule

`default_nettype wire
